// ===== design/bounded_ordered_value_list_core_assert.svh =====
// Assertion macros for the ordered value list core
`ifndef BOUNDED_ORDERED_VALUE_LIST_CORE_ASSERT_SVH
`define BOUNDED_ORDERED_VALUE_LIST_CORE_ASSERT_SVH

// clocked assertion, off while reset is applied
`define BOVL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion checked on every edge
`define BOVL_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/bovl_pkg.sv =====
package bovl_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_REM_FIRST = 3'd2,
    OP_REM_ALL   = 3'd3,
    OP_FIND      = 3'd4
  } bovl_op_e;

  typedef enum logic [2:0] {
    K_PUSH_FRONT,
    K_PUSH_BACK,
    K_DEL_FIRST,
    K_DEL_ALL,
    K_FIND,
    K_NOP
  } bovl_kind_e;

  typedef struct packed {
    logic       vld;
    bovl_kind_e kind;
  } bovl_cmd_t;

endpackage

// ===== design/bovl_front.sv =====
module bovl_front
  import bovl_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            opcode_i,
  input  logic signed [31:0]    value_i,
  output bovl_cmd_t             cmd_o,
  output logic [VALUE_BITS-1:0] val_o,
  input  logic                  pop_i
);

  bovl_kind_e            kind_q [2];
  logic [VALUE_BITS-1:0] val_q  [2];
  logic                  rp_q, wp_q;
  logic [1:0]            n_q;
  logic                  push;
  logic                  pop;
  bovl_kind_e            kind_in;
  logic [63:0]           ext;

  always_comb begin
    unique case (opcode_i)
      OP_INS_FRONT: kind_in = K_PUSH_FRONT;
      OP_INS_BACK:  kind_in = K_PUSH_BACK;
      OP_REM_FIRST: kind_in = K_DEL_FIRST;
      OP_REM_ALL:   kind_in = K_DEL_ALL;
      OP_FIND:      kind_in = K_FIND;
      default:      kind_in = K_NOP;
    endcase
  end

  assign ext        = {{32{value_i[31]}}, value_i};
  assign in_stall_o = (n_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (n_q != 2'd0);
  assign cmd_o.vld  = (n_q != 2'd0);
  assign cmd_o.kind = kind_q[rp_q];
  assign val_o      = val_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= 1'b0;
      wp_q <= 1'b0;
      n_q  <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      n_q <= n_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wp_q] <= kind_in;
      val_q[wp_q]  <= ext[VALUE_BITS-1:0];
    end
  end

endmodule

// ===== design/bovl_back.sv =====
module bovl_back
  import bovl_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bovl_cmd_t             cmd_i,
  input  logic [VALUE_BITS-1:0] val_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o,
  output logic [4:0]            removed_count_o,
  output logic [4:0]            entry_count_o,
  output logic                  overflow_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {S_IDLE, S_SCAN} state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         rd_q, rd_d;
  logic [CW-1:0]         wr_q, wr_d;
  logic [CW-1:0]         rem_q, rem_d;
  logic                  hit_q, hit_d;
  bovl_kind_e            kind_q, kind_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic                  ovld_q, ovld_d;
  logic                  ohit_q, ohit_d;
  logic [4:0]            orem_q, orem_d;
  logic [4:0]            ocnt_q, ocnt_d;
  logic                  oovf_q, oovf_d;

  logic [VALUE_BITS-1:0] mem_q [CAPACITY];
  logic [VALUE_BITS-1:0] rdata_q;
  logic [AW-1:0]         raddr, waddr;
  logic                  we;
  logic [VALUE_BITS-1:0] wdata;

  logic                  out_free, start, full, match, drop;
  logic [CW-1:0]         rem_n;
  logic                  hit_n;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] i);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, i};
    if (s >= (AW+1)'(CAPACITY)) s = s - (AW+1)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  assign out_free = !ovld_q || !out_stall_i;
  assign start    = (state_q == S_IDLE) && cmd_i.vld && out_free;
  assign pop_o    = start;
  assign full     = (cnt_q == CW'(CAPACITY));
  assign match    = (rdata_q == key_q);
  assign drop     = match && ((kind_q == K_DEL_ALL) ||
                              ((kind_q == K_DEL_FIRST) && (rem_q == '0)));
  assign rem_n    = rem_q + CW'(drop);
  assign hit_n    = hit_q | match;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    head_d  = head_q;
    rd_d    = rd_q;
    wr_d    = wr_q;
    rem_d   = rem_q;
    hit_d   = hit_q;
    kind_d  = kind_q;
    key_d   = key_q;
    ovld_d  = ovld_q && out_stall_i;
    ohit_d  = ohit_q;
    orem_d  = orem_q;
    ocnt_d  = ocnt_q;
    oovf_d  = oovf_q;
    raddr   = phys(head_q, '0);
    waddr   = phys(head_q, '0);
    we      = 1'b0;
    wdata   = val_i;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ovld_d = 1'b1;
          ohit_d = 1'b0;
          orem_d = 5'd0;
          oovf_d = 1'b0;
          ocnt_d = 5'(cnt_q);
          unique case (cmd_i.kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
              if (full) begin
                oovf_d = 1'b1;
              end else begin
                we     = 1'b1;
                cnt_d  = cnt_q + 1'b1;
                ocnt_d = 5'(cnt_q + 1'b1);
                if (cmd_i.kind == K_PUSH_FRONT) begin
                  head_d = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
                  waddr  = head_d;
                end else begin
                  waddr = phys(head_q, cnt_q[AW-1:0]);
                end
              end
            end
            K_DEL_FIRST, K_DEL_ALL, K_FIND: begin
              if (cnt_q != '0) begin
                ovld_d  = 1'b0;
                state_d = S_SCAN;
                rd_d    = CW'(1);
                wr_d    = '0;
                rem_d   = '0;
                hit_d   = 1'b0;
                kind_d  = cmd_i.kind;
                key_d   = val_i;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        rem_d = rem_n;
        hit_d = hit_n;
        if (!drop && (kind_q != K_FIND)) begin
          we    = 1'b1;
          waddr = phys(head_q, wr_q[AW-1:0]);
          wdata = rdata_q;
          wr_d  = wr_q + 1'b1;
        end
        if (rd_q < cnt_q) begin
          raddr = phys(head_q, rd_q[AW-1:0]);
          rd_d  = rd_q + 1'b1;
        end else begin
          state_d = S_IDLE;
          cnt_d   = cnt_q - rem_n;
          ovld_d  = 1'b1;
          ohit_d  = hit_n;
          orem_d  = 5'(rem_n);
          ocnt_d  = 5'(cnt_q - rem_n);
          oovf_d  = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      head_q  <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      rem_q   <= '0;
      hit_q   <= 1'b0;
      kind_q  <= K_NOP;
      key_q   <= '0;
      ovld_q  <= 1'b0;
      ohit_q  <= 1'b0;
      orem_q  <= 5'd0;
      ocnt_q  <= 5'd0;
      oovf_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      head_q  <= head_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      rem_q   <= rem_d;
      hit_q   <= hit_d;
      kind_q  <= kind_d;
      key_q   <= key_d;
      ovld_q  <= ovld_d;
      ohit_q  <= ohit_d;
      orem_q  <= orem_d;
      ocnt_q  <= ocnt_d;
      oovf_q  <= oovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  assign out_valid_o     = ovld_q;
  assign hit_o           = ohit_q;
  assign removed_count_o = orem_q;
  assign entry_count_o   = ocnt_q;
  assign overflow_o      = oovf_q;

endmodule

// ===== design/bounded_ordered_value_list_core.sv =====
// Ordered list of up to CAPACITY signed values with front/back insert,
// remove-first, remove-all and find.
// Input channel: in_valid_i/in_stall_o with opcode_i and value_i. A word is
// taken when valid is high and stall is low; a two-deep command queue holds
// words while the list engine is busy.
// Output channel: out_valid_o/out_stall_i with hit, removed_count,
// entry_count and overflow; exactly one result word per command, in order.
// Inserts, unused opcodes and scans of an empty list load the result register
// as soon as the engine takes them from the queue. Remove and find walk the list
// one entry per cycle through the single memory read port.
// Throughput: one insert per cycle while the result is not stalled; a scan
// command occupies the engine until it has walked the whole list.
// Reset empties the list and the queue; no clearing pass is needed.
// A stalled result holds steady and blocks the next command from
// completing; the queue keeps taking words until it is full.
module bounded_ordered_value_list_core
  import bovl_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [4:0]         removed_count_o,
  output logic [4:0]         entry_count_o,
  output logic               overflow_o
);

  bovl_cmd_t             cmd;
  logic [VALUE_BITS-1:0] val;
  logic                  pop;

  bovl_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .opcode_i  (opcode_i),
    .value_i   (value_i),
    .cmd_o     (cmd),
    .val_o     (val),
    .pop_i     (pop)
  );

  bovl_back #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .val_i          (val),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .removed_count_o(removed_count_o),
    .entry_count_o  (entry_count_o),
    .overflow_o     (overflow_o)
  );

endmodule

// ===== design/bovl_checker.sv =====
`include "bounded_ordered_value_list_core_assert.svh"

module bovl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       hit_o,
  input logic [4:0] removed_count_o,
  input logic [4:0] entry_count_o,
  input logic       overflow_o
);

  `BOVL_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(entry_count_o), "stalled result changed")
  `BOVL_ASSERT(a_ovf_clean, out_valid_o && overflow_o |-> !hit_o && removed_count_o == 5'd0, "overflow with hit or removal")
  `BOVL_ASSERT(a_rem_hit, out_valid_o && !hit_o |-> removed_count_o == 5'd0, "removal without hit")
  `BOVL_ASSERT_ALL(a_rst_idle, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind bounded_ordered_value_list_core bovl_checker u_bovl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .hit_o          (hit_o),
  .removed_count_o(removed_count_o),
  .entry_count_o  (entry_count_o),
  .overflow_o     (overflow_o)
);

// ===== tb/sv/bounded_ordered_value_list_core_chk.sv =====
module bounded_ordered_value_list_core_chk
  import bovl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               hit_i,
  input  logic [4:0]         removed_count_i,
  input  logic [4:0]         entry_count_i,
  input  logic               overflow_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic       hit;
    logic [4:0] removed;
    logic [4:0] entries;
    logic       ovf;
  } list_result_t;

  logic [31:0]  shadow_list[$];
  list_result_t result_q[$];

  function automatic list_result_t apply_command(logic [2:0] op, logic [31:0] v);
    list_result_t r;
    int           n;
    r = '0;
    n = 0;
    case (op)
      OP_INS_FRONT: if (shadow_list.size() >= CAPACITY) r.ovf = 1'b1;
                    else shadow_list.push_front(v);
      OP_INS_BACK:  if (shadow_list.size() >= CAPACITY) r.ovf = 1'b1;
                    else shadow_list.push_back(v);
      OP_REM_FIRST: begin
        foreach (shadow_list[i]) begin
          if (shadow_list[i] == v) begin
            shadow_list.delete(i);
            r.hit = 1'b1;
            r.removed = 5'd1;
            break;
          end
        end
      end
      OP_REM_ALL: begin
        for (int i = shadow_list.size() - 1; i >= 0; i--) begin
          if (shadow_list[i] == v) begin
            shadow_list.delete(i);
            n++;
          end
        end
        r.removed = n[4:0];
        r.hit = (n != 0);
      end
      OP_FIND: foreach (shadow_list[i]) if (shadow_list[i] == v) r.hit = 1'b1;
      default: ;
    endcase
    r.entries = 5'(shadow_list.size());
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    list_result_t e;
    list_result_t a;
    if (!rst_ni) begin
      fail_count_o <= 0;
      shadow_list.delete();
      result_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        a = '{hit_i, removed_count_i, entry_count_i, overflow_i};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, a);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = result_q.pop_front();
          if (e != a) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, a);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) result_q.push_back(apply_command(opcode_i, value_i));
    end
  end

  assign pending_o = result_q.size();

endmodule

// ===== tb/sv/bounded_ordered_value_list_core_tb.sv =====
module bounded_ordered_value_list_core_tb;
  import bovl_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         opcode_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b1;
  logic               hit_o;
  logic [4:0]         removed_count_o;
  logic [4:0]         entry_count_o;
  logic               overflow_o;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  bit                 hold_off = 1'b0;
  logic [31:0]        pool[8];

  localparam int LIMIT = 400000;

  always #10 clk_i = ~clk_i;

  bounded_ordered_value_list_core DUT (.*);

  bounded_ordered_value_list_core_chk chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .hit_i(hit_o),
    .removed_count_i(removed_count_o), .entry_count_i(entry_count_o),
    .overflow_i(overflow_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("bounded_ordered_value_list_core regression: fail");
      $finish;
    end
  end

  // receiver: random stall per word, plus one long hold-off
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      gap = (cycle_count % 3000 < 600) ? 0 : $urandom_range(0, 9);
      out_stall_i <= (gap != 0);
      if (gap != 0) begin
        repeat (gap - 1) @(negedge clk_i);
        out_stall_i <= 1'b0;
        @(negedge clk_i);
      end
      while (!(out_valid_o && !out_stall_i)) begin
        @(posedge clk_i);
        #1;
        if (out_valid_o && !out_stall_i) break;
        @(negedge clk_i);
      end
    end
  end

  task automatic send_word(logic [2:0] op, logic [31:0] v, bit nogap = 0);
    int gap;
    bit stalled;
    gap = nogap ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    value_i <= v;
    forever begin
      stalled = in_stall_o;
      @(posedge clk_i);
      @(negedge clk_i);
      if (!stalled) break;
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      default: return pool[$urandom_range(0, 7)];
    endcase
  endfunction

  initial begin
    logic [2:0] op;
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'hffff_ffff;
    pool[3] = 32'h0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // empty list corner cases
    send_word(OP_FIND, pool[0]);
    send_word(OP_REM_FIRST, pool[0]);
    send_word(OP_REM_ALL, pool[1]);
    send_word(3'd5, 32'h0);
    send_word(3'd6, 32'hffff_ffff);
    send_word(3'd7, 32'h5555_aaaa);
    // fill past capacity with duplicates
    for (int i = 0; i < 18; i++) send_word(i[0] ? OP_INS_BACK : OP_INS_FRONT, pool[i % 3]);
    send_word(OP_FIND, pool[1]);
    send_word(OP_REM_ALL, pool[0]);
    send_word(OP_REM_FIRST, pool[1]);
    send_word(OP_REM_FIRST, pool[3]);
    // back-to-back pressure while the receiver holds off
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++) send_word(3'($urandom_range(0, 4)), pick_value(), 1);
    for (int i = 0; i < 1050; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_word(op, pick_value(), (i % 300) < 60);
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("bounded_ordered_value_list_core regression: pass");
    end else begin
      $display("bounded_ordered_value_list_core regression: fail");
    end
    $finish;
  end

endmodule
